>>> design/bft_pkg.sv
`timescale 1ns / 1ps

package bft_pkg;

    // Operation codes as carried in the request's func field.
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam int SlotW  = 6;
    localparam int CountW = 7;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } key_t;

    // One table row as stored in the key RAM.
    typedef struct packed {
        logic valid;
        key_t key;
    } entry_t;

    // Classified request handed from the front to the engine.
    typedef struct packed {
        op_t              op;
        key_t             key;
        logic [SlotW-1:0] slot;
        logic             slot_ok;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_q_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } eng_ctl_t;

    typedef struct packed {
        logic             hit;
        logic             reversed;
        logic [SlotW-1:0] slot;
        status_t          status;
    } result_t;

    function automatic logic fwd_match(key_t e, key_t k);
        return e == k;
    endfunction

    function automatic logic rev_match(key_t e, key_t k);
        return (e.src_addr == k.dst_addr) && (e.dst_addr == k.src_addr) &&
               (e.sport == k.dport) && (e.dport == k.sport);
    endfunction

endpackage

>>> design/bidirectional_flow_table.sv
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   src_addr, dst_addr, src_port_in, dst_port_in,        func
//                slot_in, zero pad to 104 bits
// m_axis    out  slot_out, flow_count, zero pad to 16 bits             hit, reversed, status
//
// Lookup and add walk the slot RAM one slot per cycle (single read port);
// add stops early at the first free slot. Remove reads and checks only its
// own slot, and func 3 goes straight to the result.
// After reset a clearing pass zeroes every slot of the slot RAM;
// s_axis_tready stays low until it ends.
// A two-entry request queue keeps s_axis open while the engine works or a
// result waits in the output register for m_axis_tready, until the queue is full.
module bidirectional_flow_table #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // src_addr, dst_addr, src_port_in, dst_port_in, slot_in
    input  logic [1:0]   s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,   // slot_out, flow_count
    output logic [3:0]   m_axis_tuser    // hit, reversed, status
);

    bft_pkg::cmd_q_t             cmd_q;
    bft_pkg::eng_ctl_t           eng_ctl;
    bft_pkg::result_t            out_res;
    logic [bft_pkg::CountW-1:0]  out_cnt;

    // request decode and queue
    bft_front #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_q         (cmd_q),
        .eng_ctl       (eng_ctl)
    );

    // table walk, update and result register
    bft_engine #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_q     (cmd_q),
        .eng_ctl   (eng_ctl),
        .out_vld   (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_cnt   (out_cnt)
    );

    assign m_axis_tdata = {3'b000, out_cnt, out_res.slot};
    assign m_axis_tuser = {out_res.status, out_res.reversed, out_res.hit};

endmodule

>>> design/bft_ram.sv
`timescale 1ns / 1ps

module bft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/bft_front.sv
`timescale 1ns / 1ps

// Decodes incoming requests and holds them in a two-entry queue.
module bft_front #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [103:0]      s_axis_tdata,
    input  logic [1:0]        s_axis_tuser,
    output bft_pkg::cmd_q_t   cmd_q,
    input  bft_pkg::eng_ctl_t eng_ctl
);

    localparam int QDepth = 2;
    localparam int QAW    = $clog2(QDepth);
    localparam int QCW    = $clog2(QDepth + 1);

    bft_pkg::cmd_t   q_mem_reg [QDepth];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  cnt_reg, cnt_next;
    bft_pkg::cmd_t   dec_cmd;
    logic            push;

    // Classify: operation, key and remove-slot range check.
    always_comb
    begin
        dec_cmd.key.src_addr = s_axis_tdata[31:0];
        dec_cmd.key.dst_addr = s_axis_tdata[63:32];
        dec_cmd.key.sport    = s_axis_tdata[79:64];
        dec_cmd.key.dport    = s_axis_tdata[95:80];
        dec_cmd.slot         = s_axis_tdata[101:96];
        dec_cmd.slot_ok      = (int'(s_axis_tdata[101:96]) < TABLE_SLOTS);
        dec_cmd.op           = bft_pkg::op_t'(s_axis_tuser);
    end

    assign s_axis_tready = !eng_ctl.clearing && (cnt_reg != QCW'(QDepth));
    assign push          = s_axis_tvalid && s_axis_tready;

    assign cmd_q.valid = (cnt_reg != '0);
    assign cmd_q.cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (eng_ctl.pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !eng_ctl.pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && eng_ctl.pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

>>> design/bft_engine.sv
`timescale 1ns / 1ps

// Executes queued requests against the slot RAM, one slot per cycle.
module bft_engine #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bft_pkg::cmd_q_t                  cmd_q,
    output bft_pkg::eng_ctl_t                eng_ctl,
    output logic                             out_vld,
    input  logic                             out_ready,
    output bft_pkg::result_t                 out_res,
    output logic [bft_pkg::CountW-1:0]       out_cnt
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int EW = $bits(bft_pkg::entry_t);
    localparam logic [AW:0]   SlotsW  = (AW + 1)'(TABLE_SLOTS);
    localparam logic [AW-1:0] LastIdx = AW'(TABLE_SLOTS - 1);

    typedef enum logic [5:0] {
        S_CLEAR    = 6'b000001,
        S_IDLE     = 6'b000010,
        S_SCAN     = 6'b000100,
        S_RM_READ  = 6'b001000,
        S_RM_CHECK = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    bft_pkg::cmd_t                cmd_reg, cmd_next;
    logic [AW:0]                  issue_idx_reg, issue_idx_next;
    logic                         chk_vld_reg, chk_vld_next;
    logic [AW-1:0]                chk_idx_reg, chk_idx_next;
    logic [AW-1:0]                clr_idx_reg, clr_idx_next;
    logic                         fwd_hit_reg, fwd_hit_next;
    logic [AW-1:0]                fwd_slot_reg, fwd_slot_next;
    logic                         rev_hit_reg, rev_hit_next;
    logic [AW-1:0]                rev_slot_reg, rev_slot_next;
    logic [CW-1:0]                live_count_reg, live_count_next;
    bft_pkg::result_t             res_reg, res_next;
    logic                         out_vld_reg, out_vld_next;
    bft_pkg::result_t             out_res_reg, out_res_next;
    logic [bft_pkg::CountW-1:0]   out_cnt_reg, out_cnt_next;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    bft_pkg::entry_t              wr_entry;
    logic [AW-1:0]                rd_addr;
    logic [EW-1:0]                rd_data;
    bft_pkg::entry_t              rd_entry;
    logic                         issue;
    logic                         m_fwd, m_rev;

    bft_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = bft_pkg::entry_t'(rd_data);
    assign issue    = (state_reg == S_SCAN) && (issue_idx_reg < SlotsW);
    assign rd_addr  = (state_reg == S_RM_READ) ? AW'(cmd_reg.slot) : issue_idx_reg[AW-1:0];
    assign m_fwd    = rd_entry.valid && bft_pkg::fwd_match(rd_entry.key, cmd_reg.key);
    assign m_rev    = rd_entry.valid && bft_pkg::rev_match(rd_entry.key, cmd_reg.key);

    assign eng_ctl.clearing = (state_reg == S_CLEAR);
    assign eng_ctl.pop      = (state_reg == S_IDLE) && cmd_q.valid;

    assign out_vld = out_vld_reg;
    assign out_res = out_res_reg;
    assign out_cnt = out_cnt_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        issue_idx_next  = issue_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        clr_idx_next    = clr_idx_reg;
        fwd_hit_next    = fwd_hit_reg;
        fwd_slot_next   = fwd_slot_reg;
        rev_hit_next    = rev_hit_reg;
        rev_slot_next   = rev_slot_reg;
        live_count_next = live_count_reg;
        res_next        = res_reg;
        out_vld_next    = out_vld_reg;
        out_res_next    = out_res_reg;
        out_cnt_next    = out_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_entry        = '0;

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LastIdx)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_q.valid)
                begin
                    cmd_next       = cmd_q.cmd;
                    issue_idx_next = '0;
                    fwd_hit_next   = 1'b0;
                    rev_hit_next   = 1'b0;
                    res_next       = '0;
                    unique case (cmd_q.cmd.op)
                        bft_pkg::OP_LOOKUP,
                        bft_pkg::OP_ADD:
                        begin
                            state_next = S_SCAN;
                        end
                        bft_pkg::OP_REMOVE:
                        begin
                            res_next.slot = cmd_q.cmd.slot;
                            if (cmd_q.cmd.slot_ok)
                            begin
                                state_next = S_RM_READ;
                            end
                            else
                            begin
                                res_next.status = bft_pkg::ST_EMPTY;
                                state_next      = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                    chk_vld_next   = 1'b1;
                    chk_idx_next   = issue_idx_reg[AW-1:0];
                end
                if (chk_vld_reg)
                begin
                    if (cmd_reg.op == bft_pkg::OP_ADD)
                    begin
                        if (!rd_entry.valid)
                        begin
                            wr_en           = 1'b1;
                            wr_entry.valid  = 1'b1;
                            wr_entry.key    = cmd_reg.key;
                            live_count_next = live_count_reg + 1'b1;
                            res_next.slot   = bft_pkg::SlotW'(chk_idx_reg);
                            chk_vld_next    = 1'b0;
                            state_next      = S_DONE;
                        end
                        else if (chk_idx_reg == LastIdx)
                        begin
                            res_next.status = bft_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        // ascending scan: a later match overwrites, so highest slot wins
                        if (m_fwd)
                        begin
                            fwd_hit_next  = 1'b1;
                            fwd_slot_next = chk_idx_reg;
                        end
                        if (m_rev)
                        begin
                            rev_hit_next  = 1'b1;
                            rev_slot_next = chk_idx_reg;
                        end
                        if (chk_idx_reg == LastIdx)
                        begin
                            state_next = S_DONE;
                            if (rev_hit_next)
                            begin
                                res_next.hit      = 1'b1;
                                res_next.reversed = 1'b1;
                                res_next.slot     = bft_pkg::SlotW'(rev_slot_next);
                            end
                            else if (fwd_hit_next)
                            begin
                                res_next.hit  = 1'b1;
                                res_next.slot = bft_pkg::SlotW'(fwd_slot_next);
                            end
                        end
                    end
                end
            end
            S_RM_READ:
            begin
                state_next = S_RM_CHECK;
            end
            S_RM_CHECK:
            begin
                state_next = S_DONE;
                if (rd_entry.valid)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(cmd_reg.slot);
                    if (live_count_reg != '0)
                    begin
                        live_count_next = live_count_reg - 1'b1;
                    end
                end
                else
                begin
                    res_next.status = bft_pkg::ST_EMPTY;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_vld_next = 1'b1;
                    out_res_next = res_reg;
                    out_cnt_next = bft_pkg::CountW'(live_count_reg);
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            issue_idx_reg  <= '0;
            live_count_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            chk_vld_reg    <= chk_vld_next;
            issue_idx_reg  <= issue_idx_next;
            live_count_reg <= live_count_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        chk_idx_reg  <= chk_idx_next;
        fwd_hit_reg  <= fwd_hit_next;
        fwd_slot_reg <= fwd_slot_next;
        rev_hit_reg  <= rev_hit_next;
        rev_slot_reg <= rev_slot_next;
        res_reg      <= res_next;
        out_res_reg  <= out_res_next;
        out_cnt_reg  <= out_cnt_next;
    end

endmodule

>>> tb/flow_table_checker.sv
`timescale 1ns / 1ps

module flow_table_checker #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // src_addr, dst_addr, src_port_in, dst_port_in, slot_in
    input  logic [1:0]   s_axis_tuser,   // func
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [15:0]  m_axis_tdata,   // slot_out, flow_count
    input  logic [3:0]   m_axis_tuser,   // hit, reversed, status
    output int           errors,
    output int           pending
);

    typedef struct packed {
        logic                       hit;
        logic                       reversed;
        logic [bft_pkg::SlotW-1:0]  slot;
        bft_pkg::status_t           status;
        logic [bft_pkg::CountW-1:0] count;
    } reply_t;

    // shadow flow table
    logic          row_live [TABLE_SLOTS];
    bft_pkg::key_t row_key  [TABLE_SLOTS];
    int unsigned   live_flows;
    reply_t        replies_due [$];

    initial
    begin
        errors     = 0;
        pending    = 0;
        live_flows = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            row_live[i] = 1'b0;
        end
    end

    // Applies one request to the shadow table, returns the reply it must produce.
    function automatic reply_t apply_request(bft_pkg::op_t op, bft_pkg::key_t k,
                                             logic [bft_pkg::SlotW-1:0] slot_sel);
        reply_t r;
        int     fwd_at;
        int     rev_at;
        int     free_at;
        r       = '0;
        fwd_at  = -1;
        rev_at  = -1;
        free_at = -1;
        case (op)
            bft_pkg::OP_LOOKUP:
            begin
                // highest slot wins within a direction
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (row_live[i])
                    begin
                        if (row_key[i] == k)
                            fwd_at = i;
                        if (row_key[i].src_addr == k.dst_addr &&
                            row_key[i].dst_addr == k.src_addr &&
                            row_key[i].sport == k.dport &&
                            row_key[i].dport == k.sport)
                            rev_at = i;
                    end
                end
                if (rev_at >= 0)
                begin
                    r.hit      = 1'b1;
                    r.reversed = 1'b1;
                    r.slot     = rev_at[bft_pkg::SlotW-1:0];
                end
                else if (fwd_at >= 0)
                begin
                    r.hit  = 1'b1;
                    r.slot = fwd_at[bft_pkg::SlotW-1:0];
                end
            end
            bft_pkg::OP_ADD:
            begin
                for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                begin
                    if (!row_live[i])
                        free_at = i;
                end
                if (free_at < 0)
                    r.status = bft_pkg::ST_FULL;
                else
                begin
                    row_live[free_at] = 1'b1;
                    row_key[free_at]  = k;
                    live_flows++;
                    r.slot = free_at[bft_pkg::SlotW-1:0];
                end
            end
            bft_pkg::OP_REMOVE:
            begin
                r.slot = slot_sel;
                if (int'(slot_sel) < TABLE_SLOTS && row_live[slot_sel])
                begin
                    row_live[slot_sel] = 1'b0;
                    if (live_flows > 0)
                        live_flows--;
                end
                else
                    r.status = bft_pkg::ST_EMPTY;
            end
            default:
            begin
            end
        endcase
        r.count = live_flows[bft_pkg::CountW-1:0];
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        bft_pkg::key_t k;
        reply_t        want;
        if (rst_n)
        begin
            // replies first; a request accepted on this edge cannot answer yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("reply with none outstanding: tdata %h tuser %h",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("hit", want.hit, m_axis_tuser[0]);
                    check_field("reversed", want.reversed, m_axis_tuser[1]);
                    check_field("status", want.status, m_axis_tuser[3:2]);
                    check_field("slot_out", want.slot, m_axis_tdata[5:0]);
                    check_field("flow_count", want.count, m_axis_tdata[12:6]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                k.src_addr = s_axis_tdata[31:0];
                k.dst_addr = s_axis_tdata[63:32];
                k.sport    = s_axis_tdata[79:64];
                k.dport    = s_axis_tdata[95:80];
                replies_due.push_back(apply_request(bft_pkg::op_t'(s_axis_tuser), k,
                                                    s_axis_tdata[101:96]));
            end
        end
        pending <= replies_due.size();
    end

endmodule

>>> tb/bidirectional_flow_table_tb.sv
`timescale 1ns / 1ps

module bidirectional_flow_table_tb;

    localparam int TABLE_SLOTS = 64;
    // Slowest request walks the whole table.
    localparam int TAIL_CYCLES = 2 * TABLE_SLOTS + 8;
    // Sink hold-off long enough to fill the two-entry queue and the output reg.
    localparam int LONG_HOLD   = 400;
    // Cycles with no handshake on either channel before giving up. Covers
    // the clearing pass, the long hold-off and a few full table walks.
    localparam int QUIET_LIMIT = 4000;
    localparam int SEG_ITEMS   = 50;
    localparam int NUM_SEGS    = 9;

    // Request mix of one random segment.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } mix_t;

    // The first three fill segments push the table to full, the drains empty it again.
    mix_t plan [NUM_SEGS] = '{MIX_FILL, MIX_FILL, MIX_FILL, MIX_BALANCED, MIX_DRAIN,
                              MIX_DRAIN, MIX_BALANCED, MIX_FILL, MIX_BALANCED};

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic [103:0] s_axis_tdata  = '0;   // src_addr, dst_addr, src_port_in, dst_port_in, slot_in
    logic [1:0]   s_axis_tuser  = '0;   // func
    logic         m_axis_tready = 1'b0;
    wire          s_axis_tready;
    wire          m_axis_tvalid;
    wire  [15:0]  m_axis_tdata;         // slot_out, flow_count
    wire  [3:0]   m_axis_tuser;         // hit, reversed, status

    int errors;
    int pending;

    // Random gaps on both sides; cleared for quiet stretches and the last segment.
    logic idle_on       = 1'b1;
    // One-shot request to the sink for a long hold-off.
    logic long_hold_req = 1'b0;

    // Recently added keys, reused so lookups hit and duplicate adds happen.
    bft_pkg::key_t key_pool [$];

    always #6 clk = ~clk;

    bidirectional_flow_table #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    flow_table_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) flow_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .errors       (errors),
        .pending      (pending)
    );

    function automatic bft_pkg::key_t rand_key();
        bft_pkg::key_t k;
        k.src_addr = $urandom;
        k.dst_addr = $urandom;
        k.sport    = 16'($urandom_range(0, 65535));
        k.dport    = 16'($urandom_range(0, 65535));
        return k;
    endfunction

    // Same flow seen from the other end.
    function automatic bft_pkg::key_t flip_key(bft_pkg::key_t k);
        bft_pkg::key_t f;
        f.src_addr = k.dst_addr;
        f.dst_addr = k.src_addr;
        f.sport    = k.dport;
        f.dport    = k.sport;
        return f;
    endfunction

    // Presents one request and waits for the handshake. Called on a rising
    // edge; tvalid stays high into the next request unless a gap is taken.
    task automatic offer(bft_pkg::op_t op, bft_pkg::key_t k,
                         logic [bft_pkg::SlotW-1:0] slot_sel);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, slot_sel, k.dport, k.sport, k.dst_addr, k.src_addr};
        if (op == bft_pkg::OP_ADD)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic random_request(mix_t mix);
        int            roll;
        int            add_cut;
        int            rem_cut;
        bft_pkg::key_t k;
        bft_pkg::op_t  op;
        case (mix)
            MIX_FILL:
            begin
                add_cut = 65;
                rem_cut = 70;
            end
            MIX_DRAIN:
            begin
                add_cut = 10;
                rem_cut = 65;
            end
            default:
            begin
                add_cut = 30;
                rem_cut = 55;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_cut)
            op = bft_pkg::OP_ADD;
        else if (roll < rem_cut)
            op = bft_pkg::OP_REMOVE;
        else if (roll < rem_cut + 4)
            op = bft_pkg::OP_NOP;
        else
            op = bft_pkg::OP_LOOKUP;
        k = rand_key();
        if (op == bft_pkg::OP_LOOKUP && key_pool.size() != 0 && $urandom_range(0, 9) < 6)
        begin
            // known flow, either direction
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if ($urandom_range(0, 1) == 1)
                k = flip_key(k);
        end
        else if (op == bft_pkg::OP_ADD)
        begin
            roll = $urandom_range(0, 19);
            if (roll < 3 && key_pool.size() != 0)
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (roll == 3)
            begin
                // key equal to its own reverse
                k.dst_addr = k.src_addr;
                k.dport    = k.sport;
            end
        end
        offer(op, k, bft_pkg::SlotW'($urandom_range(0, 63)));
    endtask

    // Result side: random stall bursts, plus the one long hold-off.
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(0, 16);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Ends the run if neither channel moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        bft_pkg::key_t k1;
        bft_pkg::key_t sym;
        bft_pkg::key_t k2;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        k1  = rand_key();
        k2  = rand_key();
        sym = rand_key();
        sym.dst_addr = sym.src_addr;
        sym.dport    = sym.sport;

        // Empty table: lookup miss, removes of free slots at both ends.
        offer(bft_pkg::OP_LOOKUP, '0, '0);
        offer(bft_pkg::OP_REMOVE, '1, 6'd0);
        offer(bft_pkg::OP_REMOVE, '0, 6'd63);
        // Slots 0..5: all-zero key, all-ones key, a flow, its reverse,
        // a duplicate of it, and a key equal to its own reverse.
        offer(bft_pkg::OP_ADD, '0, 6'd63);
        offer(bft_pkg::OP_ADD, '1, 6'd0);
        offer(bft_pkg::OP_ADD, k1, '1);
        offer(bft_pkg::OP_ADD, flip_key(k1), '0);
        offer(bft_pkg::OP_ADD, k1, 6'd17);
        offer(bft_pkg::OP_ADD, sym, 6'd42);
        // Both directions match: reverse wins, highest slot among equals.
        offer(bft_pkg::OP_LOOKUP, k1, '0);
        offer(bft_pkg::OP_LOOKUP, flip_key(k1), '1);
        offer(bft_pkg::OP_LOOKUP, sym, 6'd5);
        offer(bft_pkg::OP_LOOKUP, '1, 6'd1);
        offer(bft_pkg::OP_LOOKUP, '0, 6'd2);
        // Unused func code with every bit set.
        offer(bft_pkg::OP_NOP, '1, '1);
        // Free the reverse entry: only forward matches remain for k1.
        offer(bft_pkg::OP_REMOVE, rand_key(), 6'd3);
        offer(bft_pkg::OP_LOOKUP, k1, 6'd9);
        offer(bft_pkg::OP_REMOVE, rand_key(), 6'd3);
        // Lowest free slot is reused.
        offer(bft_pkg::OP_ADD, k2, 6'd30);
        offer(bft_pkg::OP_LOOKUP, flip_key(k2), 6'd30);
        offer(bft_pkg::OP_LOOKUP, rand_key(), 6'd0);
        offer(bft_pkg::OP_REMOVE, rand_key(), 6'd0);
        offer(bft_pkg::OP_LOOKUP, '0, 6'd0);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            // last segment runs back to back on both sides
            idle_on = (seg != NUM_SEGS - 1) && ($urandom_range(0, 3) != 0);
            if (seg == 3)
                long_hold_req = 1'b1;
            if (seg == 5)
            begin
                // let the block drain completely before going on
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            repeat (SEG_ITEMS) random_request(plan[seg]);
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        // catch any stray reply after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/bft_pkg.sv
design/bft_ram.sv
design/bft_front.sv
design/bft_engine.sv
design/bidirectional_flow_table.sv
tb/flow_table_checker.sv
tb/bidirectional_flow_table_tb.sv
